### rtl/rft_pkg.sv
// Shared types and constants for the request flow table.
// Holds the flow entry record and the stream word layouts; no dependencies.
package rft_pkg;

    // field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 32;
    localparam int IDX_O_W = 8;
    localparam int HOST_O_W = 9;

    // default table depth
    localparam int RFT_TABLE_ENTRIES = 256;

    // stream word layouts
    localparam int IN_TDATA_W  = IP_W + IP_W + MAC_W + LEN_W;
    localparam int OUT_USED_W  = IDX_O_W + CNT_W + CNT_W + HOST_O_W + CNT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
    localparam int OUT_TUSER_W = 2;

    // one stored flow: key plus its counters
    typedef struct packed {
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
        logic [MAC_W-1:0] src_mac;
        logic [CNT_W-1:0] packets;
        logic [CNT_W-1:0] bytes;
    } rft_entry_t;

endpackage

### rtl/rft_cell.sv
// One cell of the flow ring: holds a single flow entry.
// Passes its entry to the next cell on every enabled cycle; uses rft_pkg.
module rft_cell (
    input  logic              clk,
    input  logic              en,
    input  rft_pkg::rft_entry_t d,
    output rft_pkg::rft_entry_t q
);
    import rft_pkg::*;

    rft_entry_t entry_reg;

    // shift the neighbor's entry in while the ring turns
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

### rtl/rft_scan.sv
// Scan controller of the flow ring: stream handshakes, key compare at the
// ring head, counter update and append at the wrap point, global totals.
// Depends on rft_pkg.
module rft_scan #(
    parameter int TABLE_ENTRIES = rft_pkg::RFT_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rft_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rft_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [rft_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  rft_pkg::rft_entry_t             head_entry,
    output rft_pkg::rft_entry_t             wrap_entry,
    output logic                            rotate
);
    import rft_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [USED_W-1:0] FULL_CNT  = USED_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [IP_W-1:0]   sip_reg;
    logic [IP_W-1:0]   dip_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              found_reg;
    logic              inserted_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  epk_reg;
    logic [CNT_W-1:0]  eby_reg;
    logic [USED_W-1:0] used_reg;
    logic [CNT_W-1:0]  ptot_reg;
    logic [CNT_W-1:0]  btot_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic              out_full_reg;
    logic [IDX_O_W-1:0] out_idx_reg;
    logic [CNT_W-1:0]  out_epk_reg;
    logic [CNT_W-1:0]  out_eby_reg;

    logic             in_use;
    logic             match;
    logic             insert;
    logic             load_out;
    logic             miss_full;
    logic [CNT_W-1:0] len_ext;
    logic [CNT_W-1:0] upd_pk;
    logic [CNT_W-1:0] upd_by;

    // handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign rotate   = (state_reg == ST_SCAN);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // compare against the entry at the ring head
    assign len_ext = CNT_W'(len_reg);
    assign in_use  = (USED_W'(step_reg) < used_reg);
    assign match   = rotate && in_use && !found_reg
                     && (head_entry.src_ip == sip_reg)
                     && (head_entry.dst_ip == dip_reg)
                     && (head_entry.src_mac == mac_reg);
    assign insert  = rotate && !found_reg && (USED_W'(step_reg) == used_reg);
    assign upd_pk  = sat_add(head_entry.packets, CNT_W'(1));
    assign upd_by  = sat_add(head_entry.bytes, len_ext);
    assign miss_full = !found_reg && !inserted_reg;

    // entry written back into the tail of the ring
    always_comb
    begin
        wrap_entry = head_entry;
        if (match)
        begin
            wrap_entry.packets = upd_pk;
            wrap_entry.bytes   = upd_by;
        end
        else if (insert)
        begin
            wrap_entry.src_ip  = sip_reg;
            wrap_entry.dst_ip  = dip_reg;
            wrap_entry.src_mac = mac_reg;
            wrap_entry.packets = CNT_W'(1);
            wrap_entry.bytes   = len_ext;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            used_reg      <= '0;
            ptot_reg      <= '0;
            btot_reg      <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            inserted_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (s_tvalid && s_tready)
            begin
                found_reg    <= 1'b0;
                inserted_reg <= 1'b0;
            end
            if (match)
            begin
                found_reg <= 1'b1;
            end
            if (insert)
            begin
                inserted_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                ptot_reg      <= sat_add(ptot_reg, CNT_W'(1));
                btot_reg      <= sat_add(btot_reg, len_ext);
                if (inserted_reg)
                begin
                    used_reg <= used_reg + USED_W'(1);
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input word, scan result and output word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sip_reg <= s_tdata[IP_W-1:0];
            dip_reg <= s_tdata[2*IP_W-1:IP_W];
            mac_reg <= s_tdata[2*IP_W+MAC_W-1:2*IP_W];
            len_reg <= s_tdata[IN_TDATA_W-1:2*IP_W+MAC_W];
        end
        if (match)
        begin
            idx_reg <= step_reg;
            epk_reg <= upd_pk;
            eby_reg <= upd_by;
        end
        else if (insert)
        begin
            idx_reg <= step_reg;
            epk_reg <= CNT_W'(1);
            eby_reg <= len_ext;
        end
        if (load_out)
        begin
            out_hit_reg  <= found_reg;
            out_full_reg <= miss_full;
            out_idx_reg  <= miss_full ? '0 : IDX_O_W'(idx_reg);
            out_epk_reg  <= miss_full ? '0 : epk_reg;
            out_eby_reg  <= miss_full ? '0 : eby_reg;
        end
    end

    assign m_tuser = {out_full_reg, out_hit_reg};
    assign m_tdata = {{OUT_PAD_W{1'b0}}, btot_reg, ptot_reg, HOST_O_W'(used_reg),
                      out_eby_reg, out_epk_reg, out_idx_reg};

    // a key is either found or appended, never both in one step
    assert property (@(posedge clk) disable iff (!rst_n) !(match && insert))
        else $error("match and append in the same step");

    // an append only happens while there is room
    assert property (@(posedge clk) disable iff (!rst_n) insert |-> (used_reg < FULL_CNT))
        else $error("append into a full table");

    // fill count never passes the table depth
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= FULL_CNT)
        else $error("fill count beyond table depth");

    // a finished scan is either a hit or an append, not both
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_DONE) |-> !(found_reg && inserted_reg))
        else $error("scan both hit and appended");

    // loading a result frees the input side in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
                     load_out |=> (out_valid_reg && s_tready))
        else $error("result load did not complete");

endmodule

### rtl/request_flow_table.sv
// Request flow table. Each input word is one request packet; the block looks its key
// (source IP, destination IP, source MAC) up among the stored flows and returns one
// result word with the flow's updated packet and byte counts and the global totals.
// Flows live in a ring of TABLE_ENTRIES cells that turns one entry per cycle past a
// single key comparator. Each packet is accepted, the ring makes one full turn, and
// the result is loaded into the output register; no new word is accepted until that
// load. A result that waits at the output does not hold off the next packet's scan.
// Stored keys need no clearing after reset; the fill count marks which cells hold
// flows. All packet and byte counters saturate.
module request_flow_table #(
    parameter int TABLE_ENTRIES = rft_pkg::RFT_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // src_ip[31:0], dst_ip[63:32], src_mac[111:64], pkt_length[127:112]
    input  logic [rft_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_index[7:0], entry_packets[39:8], entry_bytes[71:40], total_hosts[80:72],
    // total_packets[112:81], total_bytes[144:113], zero fill above
    output logic [rft_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit[0], table_full[1]
    output logic [rft_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import rft_pkg::*;

    rft_entry_t ring_q [TABLE_ENTRIES];
    rft_entry_t wrap_entry;
    logic       rotate;

    // controller at the head of the ring
    rft_scan #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .head_entry (ring_q[0]),
        .wrap_entry (wrap_entry),
        .rotate     (rotate)
    );

    // ring of flow cells, entries move toward cell zero
    for (genvar j = 0; j < TABLE_ENTRIES; j++)
    begin : g_ring
        if (j == TABLE_ENTRIES - 1)
        begin : g_tail
            rft_cell u_cell (
                .clk (clk),
                .en  (rotate),
                .d   (wrap_entry),
                .q   (ring_q[j])
            );
        end
        else
        begin : g_body
            rft_cell u_cell (
                .clk (clk),
                .en  (rotate),
                .d   (ring_q[j+1]),
                .q   (ring_q[j])
            );
        end
    end

endmodule

### verif/request_flow_table_test.sv
// Self-checking testbench for request_flow_table: a directed table of request words, then
// random traffic that reuses, perturbs and invents flow keys until the table overflows.
// Depends on rtl/rft_pkg.sv and rtl/request_flow_table.sv.
`timescale 1ns / 1ps

module request_flow_table_test;
    import rft_pkg::*;

    localparam int FLOW_SLOTS       = RFT_TABLE_ENTRIES;
    localparam int DIRECTED_ROWS    = 14;
    localparam int RANDOM_PER_PHASE = 132;
    localparam int REPORT_LIMIT     = 10;

    // one request packet as seen on the input word
    typedef struct packed {
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
        logic [MAC_W-1:0] src_mac;
        logic [LEN_W-1:0] pkt_length;
    } request_t;

    // one result word, split into its fields
    typedef struct packed {
        logic                hit;
        logic                table_full;
        logic [IDX_O_W-1:0]  entry_index;
        logic [CNT_W-1:0]    entry_packets;
        logic [CNT_W-1:0]    entry_bytes;
        logic [HOST_O_W-1:0] total_hosts;
        logic [CNT_W-1:0]    total_packets;
        logic [CNT_W-1:0]    total_bytes;
    } flow_result_t;

    // directed stimulus row; typed rows carry their result written out by hand
    typedef struct packed {
        request_t     req;
        logic         typed;
        flow_result_t want;
    } directed_row_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    idle_mode_t   idle_mode = IDLE_NONE;
    int           error_count = 0;
    flow_result_t pending_results[$];
    request_t     sent_keys[$];
    directed_row_t stim_table[DIRECTED_ROWS];

    // predictor copy of the flow table
    logic [IP_W-1:0]  flow_src_ip [FLOW_SLOTS];
    logic [IP_W-1:0]  flow_dst_ip [FLOW_SLOTS];
    logic [MAC_W-1:0] flow_src_mac[FLOW_SLOTS];
    logic [CNT_W-1:0] flow_packets[FLOW_SLOTS];
    logic [CNT_W-1:0] flow_bytes  [FLOW_SLOTS];
    int               stored_flows = 0;
    logic [CNT_W-1:0] packet_sum = '0;
    logic [CNT_W-1:0] byte_sum = '0;

    request_flow_table #(
        .TABLE_ENTRIES(FLOW_SLOTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] sat_add32(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // look the key up, update the predicted table and totals, return the result word
    function automatic flow_result_t account_request(request_t r);
        flow_result_t res;
        int slot;
        res = '0;
        slot = -1;
        for (int i = 0; i < stored_flows; i++)
        begin
            if (flow_src_ip[i] == r.src_ip && flow_dst_ip[i] == r.dst_ip &&
                flow_src_mac[i] == r.src_mac)
            begin
                slot = i;
                break;
            end
        end
        if (slot >= 0)
        begin
            flow_packets[slot] = sat_add32(flow_packets[slot], 1);
            flow_bytes[slot]   = sat_add32(flow_bytes[slot], CNT_W'(r.pkt_length));
            res.hit = 1'b1;
        end
        else if (stored_flows < FLOW_SLOTS)
        begin
            slot = stored_flows;
            flow_src_ip[slot]  = r.src_ip;
            flow_dst_ip[slot]  = r.dst_ip;
            flow_src_mac[slot] = r.src_mac;
            flow_packets[slot] = 1;
            flow_bytes[slot]   = CNT_W'(r.pkt_length);
            stored_flows++;
        end
        else
        begin
            res.table_full = 1'b1;
        end
        if (slot >= 0)
        begin
            res.entry_index   = IDX_O_W'(slot);
            res.entry_packets = flow_packets[slot];
            res.entry_bytes   = flow_bytes[slot];
        end
        packet_sum = sat_add32(packet_sum, 1);
        byte_sum   = sat_add32(byte_sum, CNT_W'(r.pkt_length));
        res.total_hosts   = HOST_O_W'(stored_flows);
        res.total_packets = packet_sum;
        res.total_bytes   = byte_sum;
        return res;
    endfunction

    function automatic int sender_idle_pct(idle_mode_t m);
        case (m)
            IDLE_SENDER: return 74;
            IDLE_BOTH:   return 10;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(idle_mode_t m);
        case (m)
            IDLE_RECEIVER: return 74;
            IDLE_BOTH:     return 10;
            default:       return 0;
        endcase
    endfunction

    // address fields lean toward all zeros and all ones now and then
    function automatic logic [IP_W-1:0] pick_ip();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return IP_W'($urandom);
        endcase
    endfunction

    function automatic logic [MAC_W-1:0] pick_mac();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom);
        endcase
    endfunction

    // random request: a key sent before, a key one bit away from one, or a fresh key
    function automatic request_t make_request();
        request_t r;
        int roll;
        roll = $urandom_range(99);
        if (roll < 60 && sent_keys.size() != 0)
        begin
            r = sent_keys[$urandom_range(sent_keys.size() - 1)];
            if (roll >= 40)
            begin
                case ($urandom_range(2))
                    0:       r.src_ip[$urandom_range(IP_W - 1)] ^= 1'b1;
                    1:       r.dst_ip[$urandom_range(IP_W - 1)] ^= 1'b1;
                    default: r.src_mac[$urandom_range(MAC_W - 1)] ^= 1'b1;
                endcase
            end
        end
        else
        begin
            r.src_ip  = pick_ip();
            r.dst_ip  = pick_ip();
            r.src_mac = pick_mac();
        end
        r.pkt_length = pick_length();
        return r;
    endfunction

    // hand one word to the block; valid stays high into the next word unless a gap is drawn
    task automatic send_request(request_t r, logic typed, flow_result_t want);
        flow_result_t predicted;
        if ($urandom_range(99) < sender_idle_pct(idle_mode))
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct(idle_mode));
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.pkt_length, r.src_mac, r.dst_ip, r.src_ip};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = account_request(r);
        pending_results.push_back(typed ? want : predicted);
        sent_keys.push_back(r);
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // receiver stalls by the current mode
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        flow_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result word with no request pending", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", CNT_W'(want.hit), CNT_W'(m_tuser[0]));
                check_field("table_full", CNT_W'(want.table_full), CNT_W'(m_tuser[1]));
                check_field("entry_index", CNT_W'(want.entry_index), CNT_W'(m_tdata[7:0]));
                check_field("entry_packets", want.entry_packets, m_tdata[39:8]);
                check_field("entry_bytes", want.entry_bytes, m_tdata[71:40]);
                check_field("total_hosts", CNT_W'(want.total_hosts), CNT_W'(m_tdata[80:72]));
                check_field("total_packets", want.total_packets, m_tdata[112:81]);
                check_field("total_bytes", want.total_bytes, m_tdata[144:113]);
            end
        end
    end

    // timeout
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial
    begin
        // first four results follow directly from an empty table
        stim_table = '{
            '{'{32'h0A00_0001, 32'h0A00_00FE, 48'h0011_2233_4455, 16'hFFFF}, 1'b1,
              '{1'b0, 1'b0, 8'd0, 32'd1, 32'h0000_FFFF, 9'd1, 32'd1, 32'h0000_FFFF}},
            '{'{32'h0A00_0001, 32'h0A00_00FE, 48'h0011_2233_4455, 16'h0000}, 1'b1,
              '{1'b1, 1'b0, 8'd0, 32'd2, 32'h0000_FFFF, 9'd1, 32'd2, 32'h0000_FFFF}},
            '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h0001}, 1'b1,
              '{1'b0, 1'b0, 8'd1, 32'd1, 32'd1, 9'd2, 32'd3, 32'h0001_0000}},
            '{'{32'h0000_0000, 32'h0000_0000, 48'h0000_0000_0000, 16'hFFFF}, 1'b1,
              '{1'b0, 1'b0, 8'd2, 32'd1, 32'h0000_FFFF, 9'd3, 32'd4, 32'h0001_FFFF}},
            // keys that differ from a stored one in a single field
            '{'{32'h0A00_0002, 32'h0A00_00FE, 48'h0011_2233_4455, 16'd100}, 1'b0, '0},
            '{'{32'h0A00_0001, 32'h0A00_00FF, 48'h0011_2233_4455, 16'd200}, 1'b0, '0},
            '{'{32'h0A00_0001, 32'h0A00_00FE, 48'h8011_2233_4455, 16'd300}, 1'b0, '0},
            // hits on the extreme keys and on the first key
            '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF}, 1'b0, '0},
            '{'{32'h0000_0000, 32'h0000_0000, 48'h0000_0000_0000, 16'h0000}, 1'b0, '0},
            '{'{32'h0A00_0001, 32'h0A00_00FE, 48'h0011_2233_4455, 16'h0001}, 1'b0, '0},
            // mixed extreme fields
            '{'{32'hFFFF_FFFF, 32'h0000_0000, 48'h0000_0000_0000, 16'h0007}, 1'b0, '0},
            '{'{32'h0000_0000, 32'hFFFF_FFFF, 48'h0000_0000_0000, 16'h8000}, 1'b0, '0},
            '{'{32'h0000_0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 16'h7FFF}, 1'b0, '0},
            '{'{32'hFFFF_FFFF, 32'h0000_0000, 48'h0000_0000_0000, 16'hFFFF}, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, no idling
        idle_mode = IDLE_NONE;
        foreach (stim_table[i])
            send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);

        // random traffic under each idling mode; the table fills and overflows on the way
        for (int p = 0; p < 4; p++)
        begin
            idle_mode = idle_mode_t'(p);
            repeat (RANDOM_PER_PHASE)
                send_request(make_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray words
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (FLOW_SLOTS + 8) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            error_count += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
